[sv/rpsth_pkg.sv]
// shared types, constants and helper functions for the rp set table
package rpsth_pkg;

   localparam int TABLE_DEPTH = 16;

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int PRIO_W   = 8;
   localparam int REQ_W    = 3;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int HASH_W   = 31;

   localparam logic [ADDR_W-1:0] SEED_MUL  = 32'd1103515245;
   localparam logic [ADDR_W-1:0] SEED_ADD  = 32'd12345;
   localparam logic [LEN_W-1:0]  MAX_LEN   = 6'd32;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ADD        = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DEL_PREFIX = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DEL_RP     = 3'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd3;
   localparam logic [REQ_W-1:0] REQ_LOOKUP     = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd5;
   localparam logic [STATUS_W-1:0] ST_MISS     = 3'd6;

   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  prefix_len;
      logic [LEN_W-1:0]  hash_len;
      logic [ADDR_W-1:0] rp;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      return (len > MAX_LEN) ? MAX_LEN : len;
   endfunction

   // len is already clamped to 0..32
   function automatic logic [ADDR_W-1:0] len_to_mask(input logic [LEN_W-1:0] len);
      return ~({ADDR_W{1'b1}} >> len);
   endfunction

   function automatic logic valid_host(input logic [ADDR_W-1:0] a);
      return (a[31:24] != 8'd0) && (a < 32'hE000_0000);
   endfunction

endpackage

[sv/rpsth_if.sv]
// request and response channel interfaces
interface rpsth_req_if;
   logic                           valid;
   logic                           ready;
   logic [rpsth_pkg::REQ_W-1:0]    req_type;
   logic [rpsth_pkg::ADDR_W-1:0]   req_group;
   logic [rpsth_pkg::LEN_W-1:0]    group_prefix_len;
   logic [rpsth_pkg::LEN_W-1:0]    req_hash_len;
   logic [rpsth_pkg::ADDR_W-1:0]   req_rp_addr;
   logic [rpsth_pkg::PRIO_W-1:0]   req_rp_prio;

   modport source (output valid, req_type, req_group, group_prefix_len, req_hash_len,
                   req_rp_addr, req_rp_prio, input ready);
   modport sink   (input valid, req_type, req_group, group_prefix_len, req_hash_len,
                   req_rp_addr, req_rp_prio, output ready);
endinterface

interface rpsth_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rpsth_pkg::STATUS_W-1:0]  status;
   logic [rpsth_pkg::ADDR_W-1:0]    chosen_rp;
   logic [rpsth_pkg::PRIO_W-1:0]    chosen_priority;
   logic [rpsth_pkg::COUNT_W-1:0]   removed_count;

   modport source (output valid, status, chosen_rp, chosen_priority, removed_count,
                   input ready);
   modport sink   (input valid, status, chosen_rp, chosen_priority, removed_count,
                   output ready);
endinterface

[sv/rp_set_table_hash_select.sv]
// rp candidate table: add, delete, clear and hash-based rp lookup
// requests are handled one at a time: each entry is scanned in S_READ and S_EVAL through the
//   single ram read port, a lookup runs each covering entry through the hash unit (S_HASH1,
//   S_HASH2), and rejected and reserved requests skip the scan; the next request is accepted
//   once the result is loaded into the output register, so a stalled result holds the table
// reset: all entries invalid, sequencer idle, no result pending
module rp_set_table_hash_select #(
   parameter int TABLE_DEPTH = rpsth_pkg::TABLE_DEPTH
) (
   input logic            clock,
   input logic            reset,
   rpsth_req_if.sink      req_bus,
   rpsth_rsp_if.source    rsp_bus
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_HASH1,
      S_HASH2,
      S_WRITE,
      S_REPLY
   } state_type;

   // sequencer state
   state_type                         state_ff, state_in;
   logic [IDX_W-1:0]                  idx_ff, idx_in;
   logic [TABLE_DEPTH-1:0]            valid_ff, valid_in;

   // captured request
   logic [rpsth_pkg::REQ_W-1:0]       op_ff, op_in;
   logic [rpsth_pkg::ADDR_W-1:0]      grp_ff, grp_in;
   logic [rpsth_pkg::ADDR_W-1:0]      pfx_ff, pfx_in;
   logic [rpsth_pkg::LEN_W-1:0]       plen_ff, plen_in;
   logic [rpsth_pkg::LEN_W-1:0]       hlen_ff, hlen_in;
   logic [rpsth_pkg::ADDR_W-1:0]      rp_ff, rp_in;
   logic [rpsth_pkg::PRIO_W-1:0]      pri_ff, pri_in;

   // scan results
   logic                              present_ff, present_in;
   logic                              free_found_ff, free_found_in;
   logic [IDX_W-1:0]                  free_idx_ff, free_idx_in;
   logic                              inh_found_ff, inh_found_in;
   logic [rpsth_pkg::LEN_W-1:0]       inh_hlen_ff, inh_hlen_in;
   logic [rpsth_pkg::COUNT_W-1:0]     removed_ff, removed_in;
   logic                              found_ff, found_in;
   logic [rpsth_pkg::PRIO_W-1:0]      best_pri_ff, best_pri_in;
   logic [rpsth_pkg::HASH_W-1:0]      best_hash_ff, best_hash_in;
   logic [rpsth_pkg::ADDR_W-1:0]      best_rp_ff, best_rp_in;
   logic [rpsth_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rpsth_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [rpsth_pkg::ADDR_W-1:0]      rsp_rp_ff, rsp_rp_in;
   logic [rpsth_pkg::PRIO_W-1:0]      rsp_pri_ff, rsp_pri_in;
   logic [rpsth_pkg::COUNT_W-1:0]     rsp_removed_ff, rsp_removed_in;

   // entry storage and hash unit
   rpsth_pkg::entry_type              ent;
   rpsth_pkg::entry_type              wr_ent;
   logic                              ram_wr_en;
   logic [rpsth_pkg::ADDR_W-1:0]      mac_operand;
   logic [rpsth_pkg::ADDR_W-1:0]      mac_result;
   logic [rpsth_pkg::HASH_W-1:0]      ent_hash;
   logic                              out_free;
   logic                              last_entry;
   logic                              ent_valid;
   logic                              same_prefix;
   logic                              covers_group;
   logic                              better;
   logic [rpsth_pkg::LEN_W-1:0]       in_plen;

   rpsth_ram #(
      .WIDTH ($bits(rpsth_pkg::entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (free_idx_ff),
      .wr_data    (wr_ent),
      .rd_addr    (idx_ff),
      .rd_data_ff (ent)
   );

   rpsth_mac u_mac (
      .clock     (clock),
      .operand   (mac_operand),
      .result_ff (mac_result)
   );

   assign req_bus.ready           = (state_ff == S_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.chosen_rp       = rsp_rp_ff;
   assign rsp_bus.chosen_priority = rsp_pri_ff;
   assign rsp_bus.removed_count   = rsp_removed_ff;

   // ram data is valid from S_EVAL on and stays put while idx holds
   assign last_entry   = (idx_ff == LAST_IDX);
   assign ent_valid    = valid_ff[idx_ff];
   assign same_prefix  = (ent.prefix == pfx_ff) && (ent.prefix_len == plen_ff);
   assign covers_group = ((grp_ff & rpsth_pkg::len_to_mask(ent.prefix_len)) == ent.prefix);
   assign in_plen      = rpsth_pkg::clamp_len(req_bus.group_prefix_len);

   // first pass masks the group, second pass folds in the entry's rp
   assign mac_operand = (state_ff == S_HASH1) ? (mac_result ^ ent.rp)
                                              : (grp_ff & rpsth_pkg::len_to_mask(ent.hash_len));
   assign ent_hash    = mac_result[rpsth_pkg::HASH_W-1:0];

   // lowest priority value, then highest hash, then highest rp
   assign better = !found_ff || (ent.prio < best_pri_ff) ||
                   ((ent.prio == best_pri_ff) &&
                    ((ent_hash > best_hash_ff) ||
                     ((ent_hash == best_hash_ff) && (ent.rp > best_rp_ff))));

   // new entry, hash length inherited from an existing identical prefix
   always_comb begin
      wr_ent.prefix     = pfx_ff;
      wr_ent.prefix_len = plen_ff;
      wr_ent.hash_len   = inh_found_ff ? inh_hlen_ff : hlen_ff;
      wr_ent.rp         = rp_ff;
      wr_ent.prio       = pri_ff;
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      valid_in       = valid_ff;
      op_in          = op_ff;
      grp_in         = grp_ff;
      pfx_in         = pfx_ff;
      plen_in        = plen_ff;
      hlen_in        = hlen_ff;
      rp_in          = rp_ff;
      pri_in         = pri_ff;
      present_in     = present_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      inh_found_in   = inh_found_ff;
      inh_hlen_in    = inh_hlen_ff;
      removed_in     = removed_ff;
      found_in       = found_ff;
      best_pri_in    = best_pri_ff;
      best_hash_in   = best_hash_ff;
      best_rp_in     = best_rp_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_rp_in      = rsp_rp_ff;
      rsp_pri_in     = rsp_pri_ff;
      rsp_removed_in = rsp_removed_ff;
      ram_wr_en      = 1'b0;

      // result taken by the sink
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in         = req_bus.req_type;
               grp_in        = req_bus.req_group;
               plen_in       = in_plen;
               pfx_in        = req_bus.req_group & rpsth_pkg::len_to_mask(in_plen);
               hlen_in       = rpsth_pkg::clamp_len(req_bus.req_hash_len);
               rp_in         = req_bus.req_rp_addr;
               pri_in        = req_bus.req_rp_prio;
               idx_in        = '0;
               present_in    = 1'b0;
               free_found_in = 1'b0;
               inh_found_in  = 1'b0;
               removed_in    = '0;
               found_in      = 1'b0;
               best_pri_in   = '0;
               best_rp_in    = '0;
               res_status_in = rpsth_pkg::ST_REJECTED;
               state_in      = S_REPLY;
               if (req_bus.req_type == rpsth_pkg::REQ_ADD) begin
                  // group must be class d and the rp a usable unicast host
                  if ((req_bus.req_group[31:28] == 4'hE) &&
                      rpsth_pkg::valid_host(req_bus.req_rp_addr)) begin
                     state_in = S_READ;
                  end
               end else if ((req_bus.req_type == rpsth_pkg::REQ_DEL_PREFIX) ||
                            (req_bus.req_type == rpsth_pkg::REQ_DEL_RP) ||
                            (req_bus.req_type == rpsth_pkg::REQ_CLEAR)) begin
                  res_status_in = rpsth_pkg::ST_DELETED;
                  state_in      = S_READ;
               end else if (req_bus.req_type == rpsth_pkg::REQ_LOOKUP) begin
                  state_in = S_READ;
               end
            end
         end

         // ram read in flight for entry idx
         S_READ: begin
            state_in = S_EVAL;
         end

         S_EVAL: begin
            state_in = last_entry ? ((op_ff == rpsth_pkg::REQ_ADD) ? S_WRITE : S_REPLY)
                                  : S_READ;
            idx_in   = idx_ff + 1'b1;
            if (op_ff == rpsth_pkg::REQ_ADD) begin
               if (!ent_valid) begin
                  if (!free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = idx_ff;
                  end
               end else if (same_prefix) begin
                  if (!inh_found_ff) begin
                     inh_found_in = 1'b1;
                     inh_hlen_in  = ent.hash_len;
                  end
                  if ((ent.rp == rp_ff) && (ent.prio == pri_ff)) begin
                     present_in = 1'b1;
                  end
               end
            end else if (op_ff == rpsth_pkg::REQ_LOOKUP) begin
               // covering entry: run it through the hash unit before moving on
               if (ent_valid && covers_group) begin
                  state_in = S_HASH1;
                  idx_in   = idx_ff;
               end
            end else begin
               if (ent_valid &&
                   ((op_ff == rpsth_pkg::REQ_CLEAR) ||
                    ((op_ff == rpsth_pkg::REQ_DEL_PREFIX) && same_prefix) ||
                    ((op_ff == rpsth_pkg::REQ_DEL_RP) && (ent.rp == rp_ff)))) begin
                  valid_in[idx_ff] = 1'b0;
                  if (removed_ff != {rpsth_pkg::COUNT_W{1'b1}}) begin
                     removed_in = removed_ff + 1'b1;
                  end
               end
            end
         end

         // first multiply-add result registered, second one issued
         S_HASH1: begin
            state_in = S_HASH2;
         end

         S_HASH2: begin
            if (better) begin
               found_in     = 1'b1;
               best_pri_in  = ent.prio;
               best_hash_in = ent_hash;
               best_rp_in   = ent.rp;
            end
            state_in = last_entry ? S_REPLY : S_READ;
            idx_in   = idx_ff + 1'b1;
         end

         S_WRITE: begin
            if (present_ff) begin
               res_status_in = rpsth_pkg::ST_PRESENT;
            end else if (!free_found_ff) begin
               res_status_in = rpsth_pkg::ST_FULL;
            end else begin
               ram_wr_en             = 1'b1;
               valid_in[free_idx_ff] = 1'b1;
               res_status_in         = rpsth_pkg::ST_ADDED;
            end
            state_in = S_REPLY;
         end

         // hand the result to the output register once it is free
         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_rp_in      = best_rp_ff;
               rsp_pri_in     = best_pri_ff;
               rsp_removed_in = removed_ff;
               if (op_ff == rpsth_pkg::REQ_LOOKUP) begin
                  rsp_status_in = found_ff ? rpsth_pkg::ST_HIT : rpsth_pkg::ST_MISS;
               end else begin
                  rsp_status_in = res_status_ff;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff       <= state_in;
      idx_ff         <= idx_in;
      valid_ff       <= valid_in;
      op_ff          <= op_in;
      grp_ff         <= grp_in;
      pfx_ff         <= pfx_in;
      plen_ff        <= plen_in;
      hlen_ff        <= hlen_in;
      rp_ff          <= rp_in;
      pri_ff         <= pri_in;
      present_ff     <= present_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      inh_found_ff   <= inh_found_in;
      inh_hlen_ff    <= inh_hlen_in;
      removed_ff     <= removed_in;
      found_ff       <= found_in;
      best_pri_ff    <= best_pri_in;
      best_hash_ff   <= best_hash_in;
      best_rp_ff     <= best_rp_in;
      res_status_ff  <= res_status_in;
      rsp_valid_ff   <= rsp_valid_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_rp_ff      <= rsp_rp_in;
      rsp_pri_ff     <= rsp_pri_in;
      rsp_removed_ff <= rsp_removed_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

[sv/rpsth_ram.sv]
// generic simple dual-port ram with registered read
module rpsth_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

[sv/rpsth_mac.sv]
// shared registered multiply-add stage of the hash: seed_mul * x + seed_add
module rpsth_mac (
   input  logic                         clock,
   input  logic [rpsth_pkg::ADDR_W-1:0] operand,
   output logic [rpsth_pkg::ADDR_W-1:0] result_ff
);

   logic [rpsth_pkg::ADDR_W-1:0] result_in;

   // low 32 bits only, wraps like the protocol hash
   assign result_in = rpsth_pkg::SEED_MUL * operand + rpsth_pkg::SEED_ADD;

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule
